// ===== design/archive_block_walker_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the archive block walker
// Concurrent checks on clk_i, disabled while rst_ni is low. Defining
// NO_ASSERTIONS turns every check into nothing.
// ---------------------------------------------------------------------------
`ifndef ARCHIVE_BLOCK_WALKER_ASSERT_SVH
`define ARCHIVE_BLOCK_WALKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds in the same cycle as the trigger
`define ABW_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("archive_block_walker: same-cycle check failed");

// Condition holds in the cycle after the trigger
`define ABW_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("archive_block_walker: next-cycle check failed");

`else

`define ABW_ASSERT_SAME(label, trig, cond)
`define ABW_ASSERT_NEXT(label, trig, cond)

`endif

`endif

// ===== design/abw_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abw_pkg
// Request types, walk phases and header layout constants of the walker.
// ---------------------------------------------------------------------------
package abw_pkg;

  // Input request: one archive byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_archive;
  } abw_in_t;

  // Output request: a name byte or the final file count
  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        last_of_name;
    logic [15:0] file_count;
  } abw_out_t;

  localparam logic KIND_NAME  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Walk phases, one-hot
  typedef enum logic [4:0] {
    PH_MARKER = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_FIELDS = 5'b00100,
    PH_NAME   = 5'b01000,
    PH_SKIP   = 5'b10000
  } abw_phase_e;

  localparam logic [7:0] FILE_BLOCK_TYPE = 8'h74;

  // Byte counts of the fixed parts
  localparam logic [4:0] MARKER_LEN = 5'd7;
  localparam logic [4:0] HEADER_LEN = 5'd7;
  localparam logic [4:0] FIELDS_LEN = 5'd25;

  // Byte positions inside the block header
  localparam logic [4:0] POS_TYPE    = 5'd2;
  localparam logic [4:0] POS_SIZE_LO = 5'd5;
  localparam logic [4:0] POS_SIZE_HI = 5'd6;

  // Byte positions inside the file fields
  localparam logic [4:0] POS_PACKED_END = 5'd4;
  localparam logic [4:0] POS_NAME_LO    = 5'd19;
  localparam logic [4:0] POS_NAME_HI    = 5'd20;

  // Header bytes counted before the name: block header plus file fields
  localparam logic [16:0] FIXED_HDR_LEN = 17'd32;

  // Output queue
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

endpackage

// ===== design/abw_out_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abw_out_fifo
// Small result queue: takes zero, one or two requests per cycle and hands out
// one per unstalled cycle. Stalls upstream when fewer than two slots are free.
// ---------------------------------------------------------------------------
module abw_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  abw_pkg::abw_out_t push0_i,
  input  abw_pkg::abw_out_t push1_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abw_pkg::abw_out_t out_req_o
);
  import abw_pkg::*;

  abw_out_t               mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]   count_q, count_d;
  logic [OUT_PTR_W-1:0]   wr_ptr_nx;
  logic                   pop;

  assign pop       = (count_q != '0) && !out_stall_i;
  assign wr_ptr_nx = wr_ptr_q + OUT_PTR_W'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + OUT_CNT_W'(push_cnt_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, first request at the write pointer, second one after it
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  assign full_o      = count_q > OUT_CNT_W'(OUT_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_req_o   = mem_q[rd_ptr_q];

endmodule

// ===== design/archive_block_walker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// archive_block_walker
// Walks the block headers of an archive byte stream and reports file names.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one archive byte
//   per request, with end_of_archive set on the final byte. Output channel
//   out_valid_o / out_stall_i / out_req_o carries name bytes (kind 0, with
//   last_of_name on the final character) and, on the final byte, the file
//   count (kind 1). A final byte that is also a name byte gives the name byte
//   first, then the count.
//   The walker takes one input byte per cycle while in_stall_o is low. Each
//   accepted byte updates the registered walk state; results land in a
//   four-entry output queue, which registers them before the output shows them.
//   in_stall_o rises only when the output queue has fewer than two free
//   entries, so a stalled receiver holds back the input once three or four
//   results are pending; nothing is dropped.
//   Reset clears the walk to the marker phase with a zero file count and an
//   empty queue. After the final byte the walk returns to that same state.
// ---------------------------------------------------------------------------
module archive_block_walker #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  abw_pkg::abw_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abw_pkg::abw_out_t out_req_o
);
  import abw_pkg::*;

  `include "archive_block_walker_assert.svh"

  abw_phase_e             phase_q, phase_d;
  logic [4:0]             fp_q, fp_d;
  logic [7:0]             type_q, type_d;
  logic [15:0]            bsize_q, bsize_d;
  logic [31:0]            packed_q, packed_d;
  logic [15:0]            nrem_q, nrem_d;
  logic [32:0]            skip_q, skip_d;
  logic [COUNT_WIDTH-1:0] files_q, files_d;

  logic                   accept;
  logic                   fifo_full;
  logic [7:0]             b;
  logic [4:0]             fp_inc;
  logic [15:0]            bsize_cur;
  logic [16:0]            used;
  logic [16:0]            rest_diff;
  logic [15:0]            rest;
  logic [15:0]            nrem_dec;
  logic [32:0]            skip_dec;
  logic                   name_emit;
  logic                   name_last;
  logic [COUNT_WIDTH+15:0] count_ext;
  logic [1:0]             push_cnt;
  abw_out_t               name_res, count_res, push0, push1;

  assign accept = in_valid_i && !fifo_full;
  assign b      = in_req_i.data_byte;
  assign fp_inc = fp_q + 5'd1;

  // Block size as updated by this byte
  always_comb begin
    bsize_cur = bsize_q;
    if (fp_q == POS_SIZE_LO) begin
      bsize_cur = {8'h00, b};
    end else if (fp_q == POS_SIZE_HI) begin
      bsize_cur = bsize_q | {b, 8'h00};
    end
  end

  // Header rest after the file fields and name, never below zero
  assign used      = FIXED_HDR_LEN + {1'b0, nrem_q};
  assign rest_diff = {1'b0, bsize_q} - used;
  assign rest      = ({1'b0, bsize_q} > used) ? rest_diff[15:0] : 16'h0000;
  assign nrem_dec  = nrem_q - 16'd1;
  assign skip_dec  = (skip_q != '0) ? skip_q - 33'd1 : skip_q;

  // Walk state update for one byte
  always_comb begin
    phase_d   = phase_q;
    fp_d      = fp_q;
    type_d    = type_q;
    bsize_d   = bsize_q;
    packed_d  = packed_q;
    nrem_d    = nrem_q;
    skip_d    = skip_q;
    files_d   = files_q;
    name_emit = 1'b0;
    name_last = 1'b0;

    unique case (phase_q)
      PH_MARKER: begin
        fp_d = fp_inc;
        if (fp_inc >= MARKER_LEN) begin
          phase_d = PH_HEADER;
          fp_d    = '0;
        end
      end
      PH_HEADER: begin
        if (fp_q == POS_TYPE) begin
          type_d = b;
          if (b == FILE_BLOCK_TYPE && files_q != {COUNT_WIDTH{1'b1}}) begin
            files_d = files_q + COUNT_WIDTH'(1);
          end
        end
        bsize_d = bsize_cur;
        fp_d    = fp_inc;
        if (fp_inc >= HEADER_LEN) begin
          fp_d = '0;
          if (type_q == FILE_BLOCK_TYPE) begin
            phase_d  = PH_FIELDS;
            packed_d = '0;
            nrem_d   = '0;
          end else begin
            skip_d  = (bsize_cur > 16'(HEADER_LEN))
                      ? {17'h0, bsize_cur - 16'(HEADER_LEN)} : '0;
            phase_d = (bsize_cur > 16'(HEADER_LEN)) ? PH_SKIP : PH_HEADER;
          end
        end
      end
      PH_FIELDS: begin
        if (fp_q < POS_PACKED_END) begin
          packed_d = packed_q | ({24'h0, b} << {fp_q[1:0], 3'b000});
        end else if (fp_q == POS_NAME_LO) begin
          nrem_d = {8'h00, b};
        end else if (fp_q == POS_NAME_HI) begin
          nrem_d = nrem_q | {b, 8'h00};
        end
        fp_d = fp_inc;
        if (fp_inc >= FIELDS_LEN) begin
          fp_d   = '0;
          skip_d = {17'h0, rest} + {1'b0, packed_q};
          if (nrem_q != '0) begin
            phase_d = PH_NAME;
          end else begin
            phase_d = (skip_d != '0) ? PH_SKIP : PH_HEADER;
          end
        end
      end
      PH_NAME: begin
        nrem_d    = nrem_dec;
        name_emit = 1'b1;
        name_last = nrem_dec == '0;
        if (nrem_dec == '0) begin
          phase_d = (skip_q != '0) ? PH_SKIP : PH_HEADER;
          fp_d    = '0;
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_HEADER;
          fp_d    = '0;
        end
      end
      default: begin
        phase_d = PH_MARKER;
        fp_d    = '0;
      end
    endcase

    // Final byte: back to the starting state
    if (in_req_i.end_of_archive) begin
      phase_d  = PH_MARKER;
      fp_d     = '0;
      type_d   = '0;
      bsize_d  = '0;
      packed_d = '0;
      nrem_d   = '0;
      skip_d   = '0;
      files_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MARKER;
      fp_q     <= '0;
      type_q   <= '0;
      bsize_q  <= '0;
      packed_q <= '0;
      nrem_q   <= '0;
      skip_q   <= '0;
      files_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      fp_q     <= fp_d;
      type_q   <= type_d;
      bsize_q  <= bsize_d;
      packed_q <= packed_d;
      nrem_q   <= nrem_d;
      skip_q   <= skip_d;
      files_q  <= files_d;
    end
  end

  // Result requests; the count includes a file block opened by this byte
  always_comb begin
    count_ext = {16'h0000, files_q};
    if (phase_q == PH_HEADER && fp_q == POS_TYPE && b == FILE_BLOCK_TYPE
        && files_q != {COUNT_WIDTH{1'b1}}) begin
      count_ext = {16'h0000, files_q + COUNT_WIDTH'(1)};
    end
  end

  always_comb begin
    name_res.kind          = KIND_NAME;
    name_res.name_byte     = b;
    name_res.last_of_name  = name_last;
    name_res.file_count    = 16'h0000;
    count_res.kind         = KIND_COUNT;
    count_res.name_byte    = 8'h00;
    count_res.last_of_name = 1'b0;
    count_res.file_count   = count_ext[15:0];
    push0    = name_emit ? name_res : count_res;
    push1    = count_res;
    push_cnt = accept ? (2'(name_emit) + 2'(in_req_i.end_of_archive)) : 2'd0;
  end

  abw_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (push0),
    .push1_i     (push1),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  assign in_stall_o = fifo_full;

  // Checks
  `ABW_ASSERT_SAME(a_name_nonzero, phase_q == PH_NAME, nrem_q != '0)
  `ABW_ASSERT_SAME(a_skip_nonzero, phase_q == PH_SKIP, skip_q != '0)
  `ABW_ASSERT_NEXT(a_final_resets, accept && in_req_i.end_of_archive,
                   phase_q == PH_MARKER && files_q == '0)
  `ABW_ASSERT_NEXT(a_result_shown, accept && in_req_i.end_of_archive, out_valid_o)

endmodule
